// ----- hw/rtl/mhpq_pkg.sv -----
// ----------------------------------------------------------------------------
// mhpq_pkg: shared types and constants for the min-heap priority queue
// Opcodes, status codes, controller states and the command/status structs.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam int VAL_W = 31;
  localparam int TGT_W = 32;
  localparam int ST_W  = 3;

  localparam logic [1:0] OP_PUSH    = 2'd0;
  localparam logic [1:0] OP_EXTRACT = 2'd1;
  localparam logic [1:0] OP_DECR    = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  localparam logic [2:0] ST_EXTRACTED = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_PUSHED    = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_DECREASED = 3'd4;
  localparam logic [2:0] ST_NOTFOUND  = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,     // classify op, set index and status
    S_SRCH_RD,   // search: read slot
    S_SRCH_CK,   // search: compare tag
    S_UP_RD,     // sift-up: read parent
    S_UP_CK,     // sift-up: compare, maybe swap
    S_EX_RD,     // extract: read root and last
    S_EX_MV,     // extract: move last to root
    S_DN_RD,     // sift-down: read both children
    S_DN_CK,     // sift-down: compare, maybe swap
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    state_t st;
    logic   take_in;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       empty;
    logic       srch_hit;
    logic       srch_end;
    logic       up_go;
    logic       dn_go;
    logic       dn_has;
  } sts_t;

endpackage

// ----- hw/rtl/min_heap_priority_queue_decrease_key_top.sv -----
// ----------------------------------------------------------------------------
// min_heap_priority_queue_decrease_key_top: binary min-heap with decrease-key
// Top level joining the sequencer and the heap datapath.
// ----------------------------------------------------------------------------
// One item at a time. Push and extract sift one heap level per read step
// and write step on the single heap RAM (sift-down reads both children at
// once). Decrease-key first scans the stored entries one by one, then
// sifts up like push. Op 3 gives no result.
module min_heap_priority_queue_decrease_key_top #(
  parameter int CAPACITY = 1024,
  parameter int TAG_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_op,
  input  logic signed [mhpq_pkg::VAL_W-1:0]  in_value,
  input  logic [mhpq_pkg::TGT_W-1:0]         in_target_op,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [mhpq_pkg::ST_W-1:0]          out_status,
  output logic signed [mhpq_pkg::VAL_W-1:0]  out_min_value,
  output logic [mhpq_pkg::TGT_W-1:0]         out_min_tag
);

  mhpq_pkg::cmd_t cmd;
  mhpq_pkg::sts_t sts;

  mhpq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  mhpq_dp #(.CAPACITY(CAPACITY), .TAG_BITS(TAG_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_op(in_op), .in_value(in_value), .in_target_op(in_target_op),
    .out_status(out_status), .out_min_value(out_min_value),
    .out_min_tag(out_min_tag)
  );

endmodule

// ----- hw/rtl/mhpq_ram.sv -----
// ----------------------------------------------------------------------------
// mhpq_ram: generic dual-port RAM
// One write port and two read ports, registered read data.
// ----------------------------------------------------------------------------
module mhpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- hw/rtl/mhpq_ctrl.sv -----
// ----------------------------------------------------------------------------
// mhpq_ctrl: operation sequencer
// Walks each operation through search, sift-up or sift-down steps.
// ----------------------------------------------------------------------------
module mhpq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  mhpq_pkg::sts_t   sts,
  output mhpq_pkg::cmd_t   cmd
);

  mhpq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mhpq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mhpq_pkg::S_IDLE: if (in_valid) state_nxt = mhpq_pkg::S_START;
      mhpq_pkg::S_START: begin
        unique case (sts.op)
          mhpq_pkg::OP_PUSH:
            state_nxt = sts.full ? mhpq_pkg::S_DONE : mhpq_pkg::S_UP_RD;
          mhpq_pkg::OP_EXTRACT:
            state_nxt = sts.empty ? mhpq_pkg::S_DONE : mhpq_pkg::S_EX_RD;
          mhpq_pkg::OP_DECR:
            state_nxt = sts.empty ? mhpq_pkg::S_DONE : mhpq_pkg::S_SRCH_RD;
          default: state_nxt = mhpq_pkg::S_IDLE;
        endcase
      end
      mhpq_pkg::S_SRCH_RD: state_nxt = mhpq_pkg::S_SRCH_CK;
      mhpq_pkg::S_SRCH_CK: begin
        if (sts.srch_hit)      state_nxt = mhpq_pkg::S_UP_RD;
        else if (sts.srch_end) state_nxt = mhpq_pkg::S_DONE;
        else                   state_nxt = mhpq_pkg::S_SRCH_RD;
      end
      mhpq_pkg::S_UP_RD: state_nxt = sts.up_go ? mhpq_pkg::S_UP_CK : mhpq_pkg::S_DONE;
      mhpq_pkg::S_UP_CK: state_nxt = sts.up_go ? mhpq_pkg::S_UP_RD : mhpq_pkg::S_DONE;
      mhpq_pkg::S_EX_RD: state_nxt = mhpq_pkg::S_EX_MV;
      mhpq_pkg::S_EX_MV: state_nxt = mhpq_pkg::S_DN_RD;
      mhpq_pkg::S_DN_RD: state_nxt = sts.dn_has ? mhpq_pkg::S_DN_CK : mhpq_pkg::S_DONE;
      mhpq_pkg::S_DN_CK: state_nxt = sts.dn_go ? mhpq_pkg::S_DN_RD : mhpq_pkg::S_DONE;
      mhpq_pkg::S_DONE: if (out_ready) state_nxt = mhpq_pkg::S_IDLE;
      default: state_nxt = mhpq_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready    = (state_r == mhpq_pkg::S_IDLE);
    out_valid   = (state_r == mhpq_pkg::S_DONE);
    cmd.st      = state_r;
    cmd.take_in = in_ready && in_valid;
  end

endmodule

// ----- hw/rtl/mhpq_dp.sv -----
// ----------------------------------------------------------------------------
// mhpq_dp: heap datapath
// Heap storage, operation counter, index registers and comparators.
// ----------------------------------------------------------------------------
module mhpq_dp #(
  parameter int CAPACITY = 1024,
  parameter int TAG_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mhpq_pkg::cmd_t             cmd,
  output mhpq_pkg::sts_t             sts,
  input  logic [1:0]                 in_op,
  input  logic signed [mhpq_pkg::VAL_W-1:0] in_value,
  input  logic [mhpq_pkg::TGT_W-1:0] in_target_op,
  output logic [mhpq_pkg::ST_W-1:0]  out_status,
  output logic signed [mhpq_pkg::VAL_W-1:0] out_min_value,
  output logic [mhpq_pkg::TGT_W-1:0] out_min_tag
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = TAG_BITS + mhpq_pkg::VAL_W;
  // tag and target are compared at the wider of the two widths
  localparam int MW = (TAG_BITS > mhpq_pkg::TGT_W) ? TAG_BITS : mhpq_pkg::TGT_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // entry = {tag, value}
  logic          we;
  logic [AW-1:0] waddr, ra, rb;
  logic [EW-1:0] wdata, rda, rdb;

  mhpq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr_a(ra), .raddr_b(rb), .rdata_a(rda), .rdata_b(rdb)
  );

  logic [1:0]          op_r;
  logic signed [mhpq_pkg::VAL_W-1:0] val_r;
  logic [mhpq_pkg::TGT_W-1:0] tgt_r;
  logic [TAG_BITS-1:0] opc_r, opc_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       i_r, i_nxt;        // current node / search index
  logic [EW-1:0]       cur_r, cur_nxt;    // entry being sifted
  logic [2:0]          st_r, st_nxt;
  logic signed [mhpq_pkg::VAL_W-1:0] mv_r, mv_nxt;
  logic [mhpq_pkg::TGT_W-1:0] mt_r, mt_nxt;

  // child indexes of i_r (wide enough to exceed count)
  logic [CW:0] lc, rc;
  logic [CW-1:0] par;
  assign lc  = {i_r, 1'b1};
  assign rc  = {i_r, 1'b0} + (CW+1)'(2);
  assign par = (i_r - CW'(1)) >> 1;

  logic signed [mhpq_pkg::VAL_W-1:0] cur_v, av, bv;
  assign cur_v = cur_r[mhpq_pkg::VAL_W-1:0];
  assign av    = rda[mhpq_pkg::VAL_W-1:0];
  assign bv    = rdb[mhpq_pkg::VAL_W-1:0];

  logic has_r, pick_r, dn_go;
  logic [EW-1:0] pk_e;
  logic [CW:0]   pk_i;
  assign has_r  = rc < {1'b0, cnt_r};
  assign pick_r = has_r && (bv < av);
  assign pk_e   = pick_r ? rdb : rda;
  assign pk_i   = pick_r ? rc : lc;
  assign dn_go  = $signed(pk_e[mhpq_pkg::VAL_W-1:0]) <= cur_v;

  logic up_ok;
  assign up_ok = cur_v < av;

  logic srch_hit;
  assign srch_hit = (MW'(rda[EW-1:mhpq_pkg::VAL_W]) == MW'(tgt_r));

  always_comb begin
    we = 1'b0; waddr = i_r[AW-1:0]; wdata = cur_r;
    ra = i_r[AW-1:0]; rb = i_r[AW-1:0];
    opc_nxt = opc_r; cnt_nxt = cnt_r; i_nxt = i_r; cur_nxt = cur_r;
    st_nxt = st_r; mv_nxt = mv_r; mt_nxt = mt_r;
    sts.op = op_r; sts.full = (cnt_r == CAP_C); sts.empty = (cnt_r == '0);
    sts.srch_hit = srch_hit;
    sts.srch_end = (i_r + CW'(1)) >= cnt_r;
    sts.up_go = 1'b0; sts.dn_go = dn_go;
    sts.dn_has = lc < {1'b0, cnt_r};
    unique case (cmd.st)
      mhpq_pkg::S_START: begin
        if (op_r != mhpq_pkg::OP_NONE && opc_r != '1) opc_nxt = opc_r + TAG_BITS'(1);
        mv_nxt = '0; mt_nxt = '0;
        unique case (op_r)
          mhpq_pkg::OP_PUSH: begin
            if (cnt_r == CAP_C) st_nxt = mhpq_pkg::ST_FULL;
            else begin
              st_nxt  = mhpq_pkg::ST_PUSHED;
              cur_nxt = {((opc_r != '1) ? opc_r + TAG_BITS'(1) : opc_r), val_r};
              i_nxt   = cnt_r;
              cnt_nxt = cnt_r + CW'(1);
            end
          end
          mhpq_pkg::OP_EXTRACT: begin
            st_nxt = (cnt_r == '0) ? mhpq_pkg::ST_EMPTY : mhpq_pkg::ST_EXTRACTED;
            i_nxt  = '0;
          end
          default: begin
            st_nxt = mhpq_pkg::ST_NOTFOUND;
            i_nxt  = '0;
          end
        endcase
      end
      mhpq_pkg::S_SRCH_CK: begin
        if (srch_hit) begin
          st_nxt = mhpq_pkg::ST_DECREASED;
          cur_nxt = {rda[EW-1:mhpq_pkg::VAL_W], val_r};
        end else i_nxt = i_r + CW'(1);
      end
      mhpq_pkg::S_UP_RD: begin
        // stop at root: write entry in place
        sts.up_go = (i_r != '0);
        ra = par[AW-1:0];
        if (i_r == '0) we = 1'b1;
      end
      mhpq_pkg::S_UP_CK: begin
        ra = par[AW-1:0];
        we = 1'b1;
        if (up_ok) begin
          sts.up_go = 1'b1;
          wdata = rda;         // parent moves down
          i_nxt = par;
        end
      end
      mhpq_pkg::S_EX_RD: begin
        ra = '0;
        rb = AW'(cnt_r - CW'(1));
        cnt_nxt = cnt_r - CW'(1);
      end
      mhpq_pkg::S_EX_MV: begin
        mv_nxt  = av;
        mt_nxt  = mhpq_pkg::TGT_W'(rda[EW-1:mhpq_pkg::VAL_W]);
        cur_nxt = rdb;
      end
      mhpq_pkg::S_DN_RD: begin
        ra = lc[AW-1:0];
        rb = rc[AW-1:0];
        if (!(lc < {1'b0, cnt_r})) we = 1'b1;
      end
      mhpq_pkg::S_DN_CK: begin
        ra = lc[AW-1:0];
        rb = rc[AW-1:0];
        we = 1'b1;
        if (dn_go) begin
          wdata = pk_e;        // child moves up
          i_nxt = pk_i[CW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opc_r <= '0;
      cnt_r <= '0;
    end else begin
      opc_r <= opc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      op_r  <= in_op;
      val_r <= in_value;
      tgt_r <= in_target_op;
    end
    i_r   <= i_nxt;
    cur_r <= cur_nxt;
    st_r  <= st_nxt;
    mv_r  <= mv_nxt;
    mt_r  <= mt_nxt;
  end

  assign out_status    = st_r;
  assign out_min_value = mv_r;
  assign out_min_tag   = mt_r;

endmodule

// ----- test/min_heap_priority_queue_decrease_key_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// min_heap_priority_queue_decrease_key_top_test: heap priority queue bench
// Drives push, extract-min and decrease-key items and runs them through a
// local heap model, including the empty, full, missing-tag and unused-opcode
// cases. Every result is compared field by field with the model, with random
// idle gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_decrease_key_top_test;

  localparam int VAL_W = mhpq_pkg::VAL_W;
  localparam int TGT_W = mhpq_pkg::TGT_W;
  localparam int ST_W  = mhpq_pkg::ST_W;
  localparam int HEAP_DEPTH = 1024;
  localparam logic [31:0] TAG_TOP = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] min_value;
    logic [TGT_W-1:0]        min_tag;
  } heap_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              in_op = mhpq_pkg::OP_NONE;
  logic signed [VAL_W-1:0] in_value = '0;
  logic [TGT_W-1:0]        in_target_op = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [ST_W-1:0]         out_status;
  logic signed [VAL_W-1:0] out_min_value;
  logic [TGT_W-1:0]        out_min_tag;

  // model state
  logic signed [VAL_W-1:0] heap_val [HEAP_DEPTH];
  logic [TGT_W-1:0]        heap_tag [HEAP_DEPTH];
  int                      heap_count = 0;
  logic [TGT_W-1:0]        op_count = '0;

  heap_result_t pending_results[$];
  int           error_count = 0;
  int           idle_pct = 0;
  int           stall_pct = 0;

  min_heap_priority_queue_decrease_key_top u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_value     (in_value),
    .in_target_op (in_target_op),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_min_value(out_min_value),
    .out_min_tag  (out_min_tag)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // overall time limit
  initial begin
    #20000000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR @%0t: %s", $realtime, what);
    error_count++;
  endtask

  task automatic swap_entries(input int a, input int b);
    logic signed [VAL_W-1:0] v;
    logic [TGT_W-1:0]        t;
    v = heap_val[a]; t = heap_tag[a];
    heap_val[a] = heap_val[b]; heap_tag[a] = heap_tag[b];
    heap_val[b] = v; heap_tag[b] = t;
  endtask

  task automatic sift_up(input int idx);
    int i;
    i = idx;
    while (i > 0 && heap_val[i] < heap_val[(i - 1) / 2]) begin
      swap_entries(i, (i - 1) / 2);
      i = (i - 1) / 2;
    end
  endtask

  task automatic heap_sink();
    int i, pick;
    i = 0;
    while (2 * i + 1 < heap_count) begin
      pick = 2 * i + 1;
      if (pick + 1 < heap_count && heap_val[pick + 1] < heap_val[pick]) pick++;
      if (!(heap_val[pick] <= heap_val[i])) break;
      swap_entries(i, pick);
      i = pick;
    end
  endtask

  // apply one item to the heap model and queue its result
  task automatic heap_apply(input logic [1:0] op, input logic signed [VAL_W-1:0] val,
                            input logic [TGT_W-1:0] target);
    heap_result_t res;
    res = '0;
    if (op == mhpq_pkg::OP_NONE) return;
    if (op_count != TAG_TOP) op_count++;
    case (op)
      mhpq_pkg::OP_PUSH: begin
        if (heap_count >= HEAP_DEPTH) begin
          res.status = mhpq_pkg::ST_FULL;
        end else begin
          heap_val[heap_count] = val;
          heap_tag[heap_count] = op_count;
          heap_count++;
          sift_up(heap_count - 1);
          res.status = mhpq_pkg::ST_PUSHED;
        end
      end
      mhpq_pkg::OP_EXTRACT: begin
        if (heap_count == 0) begin
          res.status = mhpq_pkg::ST_EMPTY;
        end else begin
          res.status = mhpq_pkg::ST_EXTRACTED;
          res.min_value = heap_val[0];
          res.min_tag = heap_tag[0];
          heap_count--;
          heap_val[0] = heap_val[heap_count];
          heap_tag[0] = heap_tag[heap_count];
          heap_sink();
        end
      end
      default: begin
        res.status = mhpq_pkg::ST_NOTFOUND;
        for (int i = 0; i < heap_count; i++) begin
          if (heap_tag[i] == target) begin
            heap_val[i] = val;
            sift_up(i);
            res.status = mhpq_pkg::ST_DECREASED;
            break;
          end
        end
      end
    endcase
    pending_results.insert(pending_results.size(), res);
  endtask

  // send one item; valid is left high so back-to-back items need no re-raise
  task automatic send_item(input logic [1:0] op, input logic signed [VAL_W-1:0] val,
                           input logic [TGT_W-1:0] target);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_value     <= val;
    in_target_op <= target;
    do @(posedge clk); while (!in_ready);
    heap_apply(op, val, target);
  endtask

  function automatic logic signed [VAL_W-1:0] rand_value();
    if ($urandom_range(3) == 0) return VAL_W'($urandom);
    return VAL_W'(int'($urandom_range(2000000000)) - 1000000000);
  endfunction

  // tag of a live entry, or a random tag when the heap is empty
  function automatic logic [TGT_W-1:0] live_tag();
    if (heap_count == 0) return $urandom;
    return heap_tag[$urandom_range(heap_count - 1)];
  endfunction

  // output stall generator
  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  // result checker
  always @(posedge clk) begin
    heap_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d", out_status));
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
        if (out_min_value !== want.min_value)
          report_mismatch($sformatf("min_value %0d, want %0d", out_min_value, want.min_value));
        if (out_min_tag !== want.min_tag)
          report_mismatch($sformatf("min_tag %0d, want %0d", out_min_tag, want.min_tag));
      end
    end
  end

  // empty heap, extremes of value and target, unused opcode
  task automatic test_basic_ops();
    send_item(mhpq_pkg::OP_EXTRACT, '0, '0);
    send_item(mhpq_pkg::OP_DECR, VAL_W'(5), 32'd1);
    send_item(mhpq_pkg::OP_PUSH, VAL_W'(-1000000000), '0);
    send_item(mhpq_pkg::OP_PUSH, VAL_W'(1000000000), TAG_TOP);
    send_item(mhpq_pkg::OP_PUSH, '0, '0);
    send_item(mhpq_pkg::OP_PUSH, '0, '0);
    send_item(mhpq_pkg::OP_NONE, VAL_W'(17), 32'd4);
    send_item(mhpq_pkg::OP_PUSH, {1'b1, {(VAL_W-1){1'b0}}}, '0);
    send_item(mhpq_pkg::OP_PUSH, {1'b0, {(VAL_W-1){1'b1}}}, '0);
    repeat (8) send_item(mhpq_pkg::OP_EXTRACT, '0, '0);
  endtask

  // hits, misses, larger new value, equal values
  task automatic test_decrease_key();
    for (int i = 0; i < 6; i++) send_item(mhpq_pkg::OP_PUSH, VAL_W'(100 * i), '0);
    send_item(mhpq_pkg::OP_DECR, VAL_W'(-50), heap_tag[heap_count - 1]);
    send_item(mhpq_pkg::OP_DECR, VAL_W'(1000000000), heap_tag[0]);
    send_item(mhpq_pkg::OP_DECR, VAL_W'(7), TAG_TOP);
    send_item(mhpq_pkg::OP_DECR, VAL_W'(200), heap_tag[heap_count - 2]);
    repeat (7) send_item(mhpq_pkg::OP_EXTRACT, '0, '0);
  endtask

  // fill to capacity, push into the full heap, search the last slot
  task automatic test_full_heap();
    while (heap_count < HEAP_DEPTH)
      send_item(mhpq_pkg::OP_PUSH, VAL_W'($urandom_range(500)), '0);
    send_item(mhpq_pkg::OP_PUSH, VAL_W'(-1), '0);
    send_item(mhpq_pkg::OP_DECR, VAL_W'(-1000000000), heap_tag[HEAP_DEPTH - 1]);
  endtask

  // random mix over the idling phases, starting from a full heap
  task automatic test_random_mix();
    int sel;
    int phase_idle [4] = '{0, 45, 0, 22};
    int phase_stall[4] = '{0, 0, 45, 22};
    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      for (int n = 0; n < 110; n++) begin
        sel = $urandom_range(99);
        if (sel < 40) send_item(mhpq_pkg::OP_PUSH, rand_value(), $urandom);
        else if (sel < 70) send_item(mhpq_pkg::OP_EXTRACT, rand_value(), $urandom);
        else if (sel < 88) send_item(mhpq_pkg::OP_DECR, rand_value(), live_tag());
        else if (sel < 95) send_item(mhpq_pkg::OP_DECR, rand_value(), $urandom);
        else send_item(mhpq_pkg::OP_NONE, rand_value(), $urandom);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_ops();
    test_decrease_key();
    stall_pct = 22;
    idle_pct = 22;
    test_full_heap();
    test_random_mix();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
